>>> design/rsef_pkg.sv
package rsef_pkg;

	localparam logic [7:0] START_BYTE   = 8'd2;
	localparam logic [7:0] END_BYTE     = 8'd3;
	localparam int         ID_FIRST_POS = 2;
	localparam int         INDEX_W      = 4;

	// Run buffer status seen by the frame stage
	typedef struct packed {
		logic busy;
		logic last_taken;
	} run_status_t;

endpackage

>>> design/rsef_frame.sv
module rsef_frame import rsef_pkg::*; #(
	parameter int ID_LENGTH    = 10,
	parameter int FRAME_LENGTH = 17
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  run_status_t run_status,
	output logic        run_load,
	output logic [7:0]  id_store [ID_LENGTH]
);

	localparam int POS_W = $clog2(FRAME_LENGTH + 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [POS_W-1:0] write_pos_q;
	logic             frame_open_q;
	logic             end_seen_q;
	logic [7:0]       store_q [ID_LENGTH];

	logic             emit;
	logic             run_free;
	logic             hold;
	logic             advance;
	logic [POS_W:0]   pos_next;
	logic [POS_W-1:0] write_pos_d;
	logic             frame_open_d;
	logic             end_seen_d;
	logic [7:0]       store_d [ID_LENGTH];

	// A run is due only on an end byte inside an open frame
	assign emit     = (byte_s1 == END_BYTE) && frame_open_q;
	assign run_free = !run_status.busy || run_status.last_taken;
	assign hold     = valid_s1 && emit && !run_free;
	assign advance  = valid_s1 && !hold;
	assign in_stall = hold;
	assign run_load = advance && emit;
	assign id_store = store_q;
	assign pos_next = {1'b0, write_pos_q} + {{POS_W{1'b0}}, 1'b1};

	always_comb begin
		write_pos_d  = write_pos_q;
		frame_open_d = frame_open_q;
		end_seen_d   = end_seen_q;
		store_d      = store_q;
		priority if (byte_s1 == START_BYTE) begin
			for (int i = 0; i < ID_LENGTH; i++) begin
				store_d[i] = 8'd0;
			end
			write_pos_d  = POS_W'(1);
			frame_open_d = 1'b1;
			end_seen_d   = 1'b0;
		end else if (byte_s1 == END_BYTE) begin
			if (write_pos_q < POS_W'(FRAME_LENGTH)) begin
				write_pos_d = pos_next[POS_W-1:0];
			end
			end_seen_d = 1'b1;
			// the run closes the frame
			if (frame_open_q) begin
				frame_open_d = 1'b0;
			end
		end else begin
			// take a data byte only inside an open frame before its end byte
			if (frame_open_q && !end_seen_q) begin
				if (pos_next >= (POS_W + 1)'(FRAME_LENGTH)) begin
					// overrun: drop the whole frame
					for (int i = 0; i < ID_LENGTH; i++) begin
						store_d[i] = 8'd0;
					end
					write_pos_d  = '0;
					frame_open_d = 1'b0;
					end_seen_d   = 1'b0;
				end else begin
					write_pos_d = pos_next[POS_W-1:0];
					for (int i = 0; i < ID_LENGTH; i++) begin
						if (int'(pos_next) == i + ID_FIRST_POS) begin
							store_d[i] = byte_s1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			write_pos_q  <= '0;
			frame_open_q <= 1'b0;
			end_seen_q   <= 1'b0;
			for (int i = 0; i < ID_LENGTH; i++) begin
				store_q[i] <= 8'd0;
			end
		end else begin
			if (!hold) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				write_pos_q  <= write_pos_d;
				frame_open_q <= frame_open_d;
				end_seen_q   <= end_seen_d;
				store_q      <= store_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

>>> design/rsef_run.sv
module rsef_run import rsef_pkg::*; #(
	parameter int ID_LENGTH = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               run_load,
	input  logic [7:0]         id_store [ID_LENGTH],
	output run_status_t        run_status,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         id_byte,
	output logic [INDEX_W-1:0] byte_index,
	output logic               last_byte
);

	localparam int IDX_W = (ID_LENGTH > 1) ? $clog2(ID_LENGTH) : 1;

	logic                     busy_q;
	logic [IDX_W-1:0]         idx_q;
	logic [7:0]               run_q [ID_LENGTH];
	logic [IDX_W+INDEX_W-1:0] idx_ext;
	logic                     take;

	assign take       = busy_q && !out_stall;
	assign out_valid  = busy_q;
	assign id_byte    = run_q[0];
	assign idx_ext    = {{INDEX_W{1'b0}}, idx_q};
	assign byte_index = idx_ext[INDEX_W-1:0];
	assign last_byte  = (idx_q == IDX_W'(ID_LENGTH - 1));

	assign run_status.busy       = busy_q;
	assign run_status.last_taken = take && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (run_load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (last_byte) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Shift the snapshot toward the head on every item taken
	always_ff @(posedge clk) begin
		if (run_load) begin
			run_q <= id_store;
		end else if (take) begin
			for (int i = 0; i < ID_LENGTH - 1; i++) begin
				run_q[i] <= run_q[i+1];
			end
		end
	end

endmodule

>>> design/rfid_stx_etx_frame_receiver.sv
// STX/ETX frame receiver for a serial tag reader. Each byte on the input channel
// is taken into an input register and from there applied to the frame state,
// unless an input stall holds it: a start byte (2) clears the ID store and opens
// a frame, data bytes fill frame positions 2 to ID_LENGTH+1 with the tag ID, a
// data byte that reaches position FRAME_LENGTH drops the frame, and an end byte (3)
// inside an open frame snapshots the store into a run buffer that delivers
// ID_LENGTH items (id_byte, byte_index, last_byte), one per cycle while the output
// is not stalled. One input byte is accepted every cycle while in_stall is low; the
// run buffer is a single snapshot, so an end byte that would start a second run
// stalls the input until the current run hands over its last item. Reset clears
// the control state and the ID store, not the input byte register or run snapshot.
module rfid_stx_etx_frame_receiver import rsef_pkg::*; #(
	parameter int ID_LENGTH    = 10,
	parameter int FRAME_LENGTH = 17
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         id_byte,
	output logic [INDEX_W-1:0] byte_index,
	output logic               last_byte
);

	run_status_t run_status;
	logic        run_load;
	logic [7:0]  id_store [ID_LENGTH];

	rsef_frame #(
		.ID_LENGTH    (ID_LENGTH),
		.FRAME_LENGTH (FRAME_LENGTH)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.run_status (run_status),
		.run_load   (run_load),
		.id_store   (id_store)
	);

	rsef_run #(
		.ID_LENGTH (ID_LENGTH)
	) u_run (
		.clk        (clk),
		.arst_n     (arst_n),
		.run_load   (run_load),
		.id_store   (id_store),
		.run_status (run_status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.id_byte    (id_byte),
		.byte_index (byte_index),
		.last_byte  (last_byte)
	);

endmodule

>>> design/rsef_checker.sv
module rsef_checker import rsef_pkg::*; #(
	parameter int ID_LENGTH = 10
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [INDEX_W-1:0] byte_index,
	input logic               last_byte
);

	// last_byte marks exactly the final index of the run
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_byte == (byte_index == INDEX_W'(ID_LENGTH - 1))))
		else $error("last_byte does not match byte_index");

	// within a run, the next item follows directly with the next index
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_byte) |=>
			(out_valid && byte_index == INDEX_W'($past(byte_index) + INDEX_W'(1))))
		else $error("run broken or index skipped");

	// a new run always starts at index zero
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_byte) |=> (!out_valid || byte_index == '0))
		else $error("run did not start at index zero");

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(byte_index)))
		else $error("stalled item changed");

endmodule

bind rfid_stx_etx_frame_receiver rsef_checker #(.ID_LENGTH(ID_LENGTH)) u_rsef_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.byte_index (byte_index),
	.last_byte  (last_byte)
);
